@@ rtl/cqst_pkg.sv @@
package cqst_pkg;

  localparam int CHANNELS = 128;
  localparam int BINS = 64;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BIN_W = $clog2(BINS);
  localparam int SUM_W = 22;
  localparam int DWELL_W = 16;
  localparam int DROP_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  localparam logic [DWELL_W-1:0] DWELL_CEILING = 16'hFFFF;

  typedef enum logic [2:0] {
    ACT_NOTE      = 3'd0,
    ACT_GET       = 3'd1,
    ACT_CLR_ENTRY = 3'd2,
    ACT_CLR_TABLE = 3'd3,
    ACT_READ_DROP = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_SAT    = 2'd2,
    ST_FEW    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_ORIGIN = 2'd0,
    CFG_MIN_DWELLS = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [2:0]        action;
    logic [7:0]        channel;
    logic signed [7:0] dwell_min_dbm;
    logic signed [7:0] dwell_mean_dbm;
    logic [15:0]       sample_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       dwell_total;
    logic signed [7:0] floor_level;
    logic signed [7:0] busy_level;
    logic signed [7:0] average_dbm;
    logic [31:0]       dropped_total;
  } out_item_t;

  typedef struct packed {
    act_e             act;
    logic             ch_ok;
    logic [IDX_W-1:0] idx;
    logic             no_samples;
    logic [BIN_W-1:0] min_bin;
    logic [BIN_W-1:0] avg_bin;
  } cmd_t;

  typedef struct packed {
    logic [SUM_W-1:0]   bin_sum;
    logic [DWELL_W-1:0] dwell_count;
    logic [BIN_W-1:0]   lowest_bin;
    logic [BIN_W-1:0]   highest_bin;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [BIN_W-1:0] to_bin(logic signed [7:0] origin,
                                               logic signed [7:0] dbm);
    logic signed [9:0] d;
    d = $signed({{2{dbm[7]}}, dbm}) - $signed({{2{origin[7]}}, origin});
    if (d < 10'sd0) begin
      return '0;
    end else if (d > $signed(10'(BINS - 1))) begin
      return BIN_W'(BINS - 1);
    end else begin
      return d[BIN_W-1:0];
    end
  endfunction

  function automatic logic signed [7:0] bin_to_dbm(logic signed [7:0] origin,
                                                   logic [7:0] bin);
    logic signed [9:0] s;
    s = $signed({{2{origin[7]}}, origin}) + $signed({2'b00, bin});
    if (s > 10'sd127) begin
      return 8'sd127;
    end else if (s < -10'sd128) begin
      return -8'sd128;
    end else begin
      return s[7:0];
    end
  endfunction

endpackage

@@ rtl/cqst_ram.sv @@
module cqst_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                       wdata_i,
  input  logic                               re_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                       rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cqst_front.sv @@
module cqst_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cqst_pkg::in_item_t    in_data_i,
  input  logic signed [7:0]     origin_i,
  output logic                  cmd_valid_o,
  output cqst_pkg::cmd_t        cmd_o,
  input  logic                  cmd_pop_i
);

  cqst_pkg::cmd_t buf_q [2];
  cqst_pkg::cmd_t cmd_d;
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push;
  logic           pop;

  // classify the incoming transaction
  always_comb begin
    cmd_d.act        = cqst_pkg::act_e'(in_data_i.action);
    cmd_d.ch_ok      = {1'b0, in_data_i.channel} < 9'(cqst_pkg::CHANNELS);
    cmd_d.idx        = in_data_i.channel[cqst_pkg::IDX_W-1:0];
    cmd_d.no_samples = in_data_i.sample_count == 16'd0;
    cmd_d.min_bin    = cqst_pkg::to_bin(origin_i, in_data_i.dwell_min_dbm);
    cmd_d.avg_bin    = cqst_pkg::to_bin(origin_i, in_data_i.dwell_mean_dbm);
  end

  assign in_stall_o  = cnt_q == 2'd2;
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

@@ rtl/cqst_div.sv @@
module cqst_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cqst_pkg::SUM_W-1:0]    dividend_i,
  input  logic [cqst_pkg::DWELL_W-1:0]  divisor_i,
  output logic                          busy_o,
  output logic [cqst_pkg::SUM_W-1:0]    quotient_o
);

  logic [cqst_pkg::SUM_W-1:0]     quo_q;
  logic [cqst_pkg::DWELL_W-1:0]   rem_q;
  logic [cqst_pkg::DWELL_W-1:0]   dvs_q;
  logic [cqst_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic [cqst_pkg::DWELL_W:0]     rem_sh;
  logic [cqst_pkg::DWELL_W-1:0]   rem_sub;
  logic                           qbit;

  // one restoring step per cycle
  always_comb begin
    rem_sh  = {rem_q, quo_q[cqst_pkg::SUM_W-1]};
    qbit    = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh[cqst_pkg::DWELL_W-1:0] - dvs_q;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[cqst_pkg::SUM_W-2:0], qbit};
      rem_q <= qbit ? rem_sub : rem_sh[cqst_pkg::DWELL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= cqst_pkg::DIV_CNT_W'(cqst_pkg::SUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - cqst_pkg::DIV_CNT_W'(1);
      if (cnt_q == cqst_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/cqst_back.sv @@
module cqst_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  cqst_pkg::cmd_t               cmd_i,
  output logic                         cmd_pop_o,
  input  logic signed [7:0]            origin_i,
  input  logic [cqst_pkg::DWELL_W-1:0] min_dwells_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output cqst_pkg::out_item_t          out_data_o
);

  cqst_pkg::back_state_e           state_q, state_d;
  cqst_pkg::cmd_t                  cmd_q;
  cqst_pkg::out_item_t             res_q, res_d;
  cqst_pkg::out_item_t             out_q;
  logic                            out_valid_q, out_valid_d;
  logic [cqst_pkg::DROP_W-1:0]     drop_q, drop_d;
  logic [cqst_pkg::CHANNELS-1:0]   vbit_q, vbit_d;

  logic                            ram_re;
  logic                            ram_we;
  logic [cqst_pkg::ENTRY_W-1:0]    ram_rdata;
  cqst_pkg::entry_t                ent;
  cqst_pkg::entry_t                ent_new;
  logic                            first;

  logic                            div_start;
  logic                            div_busy;
  logic [cqst_pkg::SUM_W-1:0]      div_quo;
  logic [7:0]                      avg;

  cqst_ram #(
    .W(cqst_pkg::ENTRY_W),
    .D(cqst_pkg::CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_q.idx),
    .wdata_i (ent_new),
    .re_i    (ram_re),
    .raddr_i (cmd_i.idx),
    .rdata_o (ram_rdata)
  );

  cqst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ent.bin_sum),
    .divisor_i  (ent.dwell_count),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // entries without a valid bit read as cleared
  always_comb begin
    ent   = vbit_q[cmd_q.idx] ? cqst_pkg::entry_t'(ram_rdata) : '0;
    first = ent.dwell_count == '0;
    ent_new.bin_sum     = ent.bin_sum + cqst_pkg::SUM_W'(cmd_q.avg_bin);
    ent_new.dwell_count = ent.dwell_count + cqst_pkg::DWELL_W'(1);
    ent_new.lowest_bin  = (first || cmd_q.min_bin < ent.lowest_bin) ?
                          cmd_q.min_bin : ent.lowest_bin;
    ent_new.highest_bin = (first || cmd_q.avg_bin > ent.highest_bin) ?
                          cmd_q.avg_bin : ent.highest_bin;
    avg = (|div_quo[cqst_pkg::SUM_W-1:8]) ? 8'hFF : div_quo[7:0];
  end

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    drop_d      = drop_q;
    vbit_d      = vbit_q;
    out_valid_d = out_valid_q;
    cmd_pop_o   = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    div_start   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      cqst_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          ram_re    = 1'b1;
          state_d   = cqst_pkg::BK_EXEC;
        end
      end
      cqst_pkg::BK_EXEC: begin
        res_d        = '0;
        res_d.status = cqst_pkg::ST_DONE;
        state_d      = cqst_pkg::BK_DONE;
        case (cmd_q.act)
          cqst_pkg::ACT_NOTE: begin
            if (!cmd_q.ch_ok || cmd_q.no_samples) begin
              drop_d       = drop_q + cqst_pkg::DROP_W'(1);
              res_d.status = cqst_pkg::ST_REJECT;
            end else if (ent.dwell_count == cqst_pkg::DWELL_CEILING) begin
              res_d.status = cqst_pkg::ST_SAT;
            end else begin
              ram_we              = 1'b1;
              vbit_d[cmd_q.idx]   = 1'b1;
            end
          end
          cqst_pkg::ACT_GET: begin
            if (!cmd_q.ch_ok) begin
              res_d.status = cqst_pkg::ST_REJECT;
            end else if (ent.dwell_count < min_dwells_i) begin
              res_d.status = cqst_pkg::ST_FEW;
            end else begin
              res_d.dwell_total = ent.dwell_count;
              res_d.floor_level = cqst_pkg::bin_to_dbm(origin_i, 8'(ent.lowest_bin));
              res_d.busy_level  = cqst_pkg::bin_to_dbm(origin_i, 8'(ent.highest_bin));
              if (first) begin
                res_d.average_dbm = cqst_pkg::bin_to_dbm(origin_i, 8'd0);
              end else begin
                div_start = 1'b1;
                state_d   = cqst_pkg::BK_DIV;
              end
            end
          end
          cqst_pkg::ACT_CLR_ENTRY: begin
            if (!cmd_q.ch_ok) begin
              res_d.status = cqst_pkg::ST_REJECT;
            end else begin
              vbit_d[cmd_q.idx] = 1'b0;
            end
          end
          cqst_pkg::ACT_CLR_TABLE: begin
            vbit_d = '0;
            drop_d = '0;
          end
          cqst_pkg::ACT_READ_DROP: begin
            res_d.status = cqst_pkg::ST_DONE;
          end
          default: begin
            res_d.status = cqst_pkg::ST_REJECT;
          end
        endcase
      end
      cqst_pkg::BK_DIV: begin
        if (!div_busy) begin
          res_d.average_dbm = cqst_pkg::bin_to_dbm(origin_i, avg);
          state_d           = cqst_pkg::BK_DONE;
        end
      end
      cqst_pkg::BK_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          res_d.dropped_total = drop_q;
          out_valid_d         = 1'b1;
          state_d             = cqst_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = cqst_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    res_q <= res_d;
    if (state_q == cqst_pkg::BK_DONE && (!out_valid_q || !out_stall_i)) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cqst_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      drop_q      <= '0;
      vbit_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      drop_q      <= drop_d;
      vbit_q      <= vbit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/channel_quality_stats_table.sv @@
// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o  in_data_i   (cqst_pkg::in_item_t)
// out       output     out_valid_o/out_stall_i out_data_o (cqst_pkg::out_item_t)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a transaction passes through the back end as table read, update, result
// a get that needs the division also runs the bit-serial 22-by-16 divider
// a two-entry command queue keeps taking input while the back end or the output waits, until full
// reset clears per-channel valid bits at once, so the table needs no clearing pass
module channel_quality_stats_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  cqst_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output cqst_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cqst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cqst_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic signed [7:0]            origin_q;
  logic [cqst_pkg::DWELL_W-1:0] min_dwells_q;
  logic                         cmd_valid;
  logic                         cmd_pop;
  cqst_pkg::cmd_t               cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q     <= -8'sd100;
      min_dwells_q <= cqst_pkg::DWELL_W'(4);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cqst_pkg::CFG_BIN_ORIGIN: origin_q     <= cfg_data_i[7:0];
        cqst_pkg::CFG_MIN_DWELLS: min_dwells_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  cqst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .origin_i    (origin_q),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  cqst_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .origin_i     (origin_q),
    .min_dwells_i (min_dwells_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

@@ tb/channel_quality_stats_checker.sv @@
module channel_quality_stats_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  cqst_pkg::in_item_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  cqst_pkg::out_item_t             out_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [cqst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cqst_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              mismatch_count_o,
  output int                              outstanding_o
);

  logic signed [7:0]            origin_dbm;
  logic [15:0]                  report_min_dwells;
  logic [cqst_pkg::SUM_W-1:0]   avg_bin_sum [cqst_pkg::CHANNELS];
  logic [cqst_pkg::DWELL_W-1:0] dwells [cqst_pkg::CHANNELS];
  logic [cqst_pkg::BIN_W-1:0]   lowest_min_bin [cqst_pkg::CHANNELS];
  logic [cqst_pkg::BIN_W-1:0]   highest_avg_bin [cqst_pkg::CHANNELS];
  logic [cqst_pkg::DROP_W-1:0]  dropped_notes;

  cqst_pkg::out_item_t expected_reports[$];
  int                  fail_count;

  assign mismatch_count_o = fail_count;

  function automatic logic [cqst_pkg::BIN_W-1:0] bin_of(input logic signed [7:0] dbm);
    int d;
    d = int'(dbm) - int'(origin_dbm);
    if (d < 0) begin
      return '0;
    end
    if (d > cqst_pkg::BINS - 1) begin
      return cqst_pkg::BIN_W'(cqst_pkg::BINS - 1);
    end
    return cqst_pkg::BIN_W'(d);
  endfunction

  function automatic logic [7:0] level_of(input logic [7:0] bin);
    int s;
    s = int'(origin_dbm) + int'(bin);
    if (s > 127) begin
      s = 127;
    end else if (s < -128) begin
      s = -128;
    end
    return 8'(s);
  endfunction

  function automatic cqst_pkg::out_item_t predict_report(input cqst_pkg::in_item_t cmd);
    cqst_pkg::out_item_t        r;
    logic [cqst_pkg::IDX_W-1:0] idx;
    logic                       ch_ok;
    logic [cqst_pkg::BIN_W-1:0] mb;
    logic [cqst_pkg::BIN_W-1:0] ab;
    logic [cqst_pkg::SUM_W-1:0] avg;
    r = '0;
    idx = cmd.channel[cqst_pkg::IDX_W-1:0];
    ch_ok = {1'b0, cmd.channel} < 9'(cqst_pkg::CHANNELS);
    case (cmd.action)
      cqst_pkg::ACT_NOTE: begin
        if (!ch_ok || cmd.sample_count == '0) begin
          dropped_notes = dropped_notes + cqst_pkg::DROP_W'(1);
          r.status = cqst_pkg::ST_REJECT;
        end else if (dwells[idx] == cqst_pkg::DWELL_CEILING) begin
          r.status = cqst_pkg::ST_SAT;
        end else begin
          mb = bin_of(cmd.dwell_min_dbm);
          ab = bin_of(cmd.dwell_mean_dbm);
          if (dwells[idx] == '0 || mb < lowest_min_bin[idx]) begin
            lowest_min_bin[idx] = mb;
          end
          if (dwells[idx] == '0 || ab > highest_avg_bin[idx]) begin
            highest_avg_bin[idx] = ab;
          end
          avg_bin_sum[idx] = avg_bin_sum[idx] + cqst_pkg::SUM_W'(ab);
          dwells[idx] = dwells[idx] + cqst_pkg::DWELL_W'(1);
        end
      end
      cqst_pkg::ACT_GET: begin
        if (!ch_ok) begin
          r.status = cqst_pkg::ST_REJECT;
        end else if (dwells[idx] < report_min_dwells) begin
          r.status = cqst_pkg::ST_FEW;
        end else begin
          avg = '0;
          if (dwells[idx] != '0) begin
            avg = avg_bin_sum[idx] / cqst_pkg::SUM_W'(dwells[idx]);
          end
          if (avg > cqst_pkg::SUM_W'(255)) begin
            avg = cqst_pkg::SUM_W'(255);
          end
          r.status = cqst_pkg::ST_DONE;
          r.dwell_total = dwells[idx];
          r.floor_level = level_of(8'(lowest_min_bin[idx]));
          r.busy_level = level_of(8'(highest_avg_bin[idx]));
          r.average_dbm = level_of(avg[7:0]);
        end
      end
      cqst_pkg::ACT_CLR_ENTRY: begin
        if (!ch_ok) begin
          r.status = cqst_pkg::ST_REJECT;
        end else begin
          avg_bin_sum[idx] = '0;
          dwells[idx] = '0;
          lowest_min_bin[idx] = '0;
          highest_avg_bin[idx] = '0;
        end
      end
      cqst_pkg::ACT_CLR_TABLE: begin
        for (int i = 0; i < cqst_pkg::CHANNELS; i++) begin
          avg_bin_sum[i] = '0;
          dwells[i] = '0;
          lowest_min_bin[i] = '0;
          highest_avg_bin[i] = '0;
        end
        dropped_notes = '0;
      end
      cqst_pkg::ACT_READ_DROP: r.status = cqst_pkg::ST_DONE;
      default: r.status = cqst_pkg::ST_REJECT;
    endcase
    r.dropped_total = dropped_notes;
    return r;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cqst_pkg::out_item_t want;
    if (!rst_ni) begin
      origin_dbm = -8'sd100;
      report_min_dwells = 16'd4;
      for (int i = 0; i < cqst_pkg::CHANNELS; i++) begin
        avg_bin_sum[i] = '0;
        dwells[i] = '0;
        lowest_min_bin[i] = '0;
        highest_avg_bin[i] = '0;
      end
      dropped_notes = '0;
      expected_reports.delete();
      fail_count = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          cqst_pkg::CFG_BIN_ORIGIN: origin_dbm = cfg_data_i[7:0];
          cqst_pkg::CFG_MIN_DWELLS: report_min_dwells = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_reports.push_back(predict_report(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("status", want.status, out_data_i.status);
          compare_field("dwell_total", want.dwell_total, out_data_i.dwell_total);
          compare_field("floor_level", want.floor_level, out_data_i.floor_level);
          compare_field("busy_level", want.busy_level, out_data_i.busy_level);
          compare_field("average_dbm", want.average_dbm, out_data_i.average_dbm);
          compare_field("dropped_total", want.dropped_total, out_data_i.dropped_total);
        end
      end
      outstanding_o <= expected_reports.size();
    end
  end

endmodule

@@ tb/channel_quality_stats_table_tb.sv @@
module channel_quality_stats_table_tb;

  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          WATCHDOG_LIMIT  = 5000;
  localparam int          DRAIN_GAP       = 30;
  localparam int          RANDOM_PER_PHASE = 350;
  localparam logic [2:0]  ACT_UNUSED_LO   = 3'(cqst_pkg::ACT_READ_DROP) + 3'd1;
  localparam logic [2:0]  ACT_CODE_MAX    = 3'h7;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid;
  logic                            in_stall;
  cqst_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_stall;
  cqst_pkg::out_item_t             out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [cqst_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cqst_pkg::CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int send_idle_pct;
  int recv_stall_pct;
  int cur_origin;
  int quiet_cycles;
  bit hold_off_req;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  channel_quality_stats_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  channel_quality_stats_checker chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  // receiver, with one long hold-off in the first random phase to back the block up
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("channel_quality_stats_table: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic cqst_pkg::in_item_t make_cmd(input logic [2:0] act, input int ch,
                                                  input int min_dbm, input int avg_dbm,
                                                  input int samples);
    cqst_pkg::in_item_t c;
    c.action = act;
    c.channel = 8'(ch);
    c.dwell_min_dbm = 8'(min_dbm);
    c.dwell_mean_dbm = 8'(avg_dbm);
    c.sample_count = 16'(samples);
    return c;
  endfunction

  task automatic send_item(input cqst_pkg::in_item_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic write_reg(input cqst_pkg::cfg_reg_e idx,
                           input logic [cqst_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_origin(input int dbm);
    cur_origin = dbm;
    write_reg(cqst_pkg::CFG_BIN_ORIGIN, {8'($urandom_range(255)), 8'(dbm)});
  endtask

  // dbm near the binned window half of the time, anything otherwise
  function automatic int pick_dbm();
    if ($urandom_range(1)) begin
      return cur_origin + int'($urandom_range(67)) - 4;
    end
    return int'($urandom_range(255));
  endfunction

  task automatic random_traffic(input int count, input bit with_hold_off);
    int         pick;
    int         ch;
    int         samples;
    logic [2:0] act;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      ch = $urandom_range(7);
      samples = $urandom_range(65535, 1);
      if (pick < 48) begin
        act = cqst_pkg::ACT_NOTE;
      end else if (pick < 74) begin
        act = cqst_pkg::ACT_GET;
      end else if (pick < 77) begin
        act = cqst_pkg::ACT_CLR_ENTRY;
      end else if (pick < 78) begin
        act = cqst_pkg::ACT_CLR_TABLE;
      end else if (pick < 83) begin
        act = cqst_pkg::ACT_READ_DROP;
      end else if (pick < 87) begin
        act = 3'($urandom_range(ACT_CODE_MAX, ACT_UNUSED_LO));
      end else begin
        act = 3'($urandom_range(cqst_pkg::ACT_READ_DROP));
        ch = $urandom_range(255);
      end
      if ($urandom_range(19) == 0) begin
        samples = 0;
      end
      if ($urandom_range(9) == 0) begin
        ch = $urandom_range(cqst_pkg::CHANNELS - 1);
      end
      if (with_hold_off && n == count / 3) begin
        hold_off_req = 1'b1;
      end
      send_item(make_cmd(act, ch, pick_dbm(), pick_dbm(), samples));
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= cqst_pkg::CFG_BIN_ORIGIN;
    cfg_data <= '0;
    quiet_cycles <= 0;
    hold_off_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_origin = -100;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings
    send_item(make_cmd(cqst_pkg::ACT_READ_DROP, 0, 0, 0, 0));
    send_item(make_cmd(cqst_pkg::ACT_GET, 0, 0, 0, 0));
    send_item(make_cmd(cqst_pkg::ACT_NOTE, 200, -60, -60, 5));
    send_item(make_cmd(cqst_pkg::ACT_NOTE, 255, -60, -60, 65535));
    send_item(make_cmd(cqst_pkg::ACT_NOTE, 5, -20, -30, 0));
    send_item(make_cmd(cqst_pkg::ACT_NOTE, 0, -128, 127, 1));
    send_item(make_cmd(cqst_pkg::ACT_NOTE, 0, 127, -128, 65535));
    send_item(make_cmd(cqst_pkg::ACT_NOTE, 0, -90, -55, 32768));
    send_item(make_cmd(cqst_pkg::ACT_GET, 0, 0, 0, 0));
    send_item(make_cmd(cqst_pkg::ACT_NOTE, 0, -101, -36, 1));
    send_item(make_cmd(cqst_pkg::ACT_GET, 0, 0, 0, 0));
    send_item(make_cmd(cqst_pkg::ACT_GET, 255, 0, 0, 0));
    send_item(make_cmd(cqst_pkg::ACT_NOTE, 127, -70, -65, 4660));
    send_item(make_cmd(cqst_pkg::ACT_CLR_ENTRY, 128, 0, 0, 0));
    send_item(make_cmd(cqst_pkg::ACT_CLR_ENTRY, 0, 0, 0, 0));
    send_item(make_cmd(cqst_pkg::ACT_GET, 0, 0, 0, 0));
    send_item(make_cmd(ACT_UNUSED_LO, 0, -1, -1, 65535));
    send_item(make_cmd(ACT_UNUSED_LO + 3'd1, 255, 127, -128, 1));
    send_item(make_cmd(ACT_CODE_MAX, 127, -128, 127, 0));
    send_item(make_cmd(cqst_pkg::ACT_CLR_TABLE, 0, 0, 0, 0));
    send_item(make_cmd(cqst_pkg::ACT_READ_DROP, 0, 0, 0, 0));

    // origin raised to 64, then at its bottom, empty entry readable
    drain();
    write_reg(cqst_pkg::CFG_MIN_DWELLS, 16'd0);
    set_origin(64);
    send_item(make_cmd(cqst_pkg::ACT_GET, 3, 0, 0, 0));
    send_item(make_cmd(cqst_pkg::ACT_NOTE, 127, -128, 127, 7));
    send_item(make_cmd(cqst_pkg::ACT_GET, 127, 0, 0, 0));
    drain();
    set_origin(-128);
    send_item(make_cmd(cqst_pkg::ACT_GET, 127, 0, 0, 0));

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          set_origin(-100);
          write_reg(cqst_pkg::CFG_MIN_DWELLS, 16'd4);
        end
        1: begin
          send_idle_pct = 87;
          recv_stall_pct = 0;
          set_origin(-128);
          write_reg(cqst_pkg::CFG_MIN_DWELLS, 16'd0);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 87;
          set_origin(64);
          write_reg(cqst_pkg::CFG_MIN_DWELLS, 16'd1);
        end
        default: begin
          send_idle_pct = 37;
          recv_stall_pct = 37;
          set_origin(int'($urandom_range(192)) - 128);
          write_reg(cqst_pkg::CFG_MIN_DWELLS, 16'($urandom_range(6)));
        end
      endcase
      random_traffic(RANDOM_PER_PHASE, phase == 0);
    end

    drain();
    if (mismatches == 0) begin
      $display("channel_quality_stats_table: match");
    end else begin
      $display("channel_quality_stats_table: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cqst_pkg.sv
rtl/cqst_ram.sv
rtl/cqst_front.sv
rtl/cqst_div.sv
rtl/cqst_back.sv
rtl/channel_quality_stats_table.sv
tb/channel_quality_stats_checker.sv
tb/channel_quality_stats_table_tb.sv
